@@ design/minifloat_add_multiply_core_macros.svh @@
// Assertion macros for the minifloat add/multiply core.
// Included by the top level; needs nothing else. Bodies are empty for synthesis.
`ifndef MINIFLOAT_ADD_MULTIPLY_CORE_MACROS_SVH
`define MINIFLOAT_ADD_MULTIPLY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside of reset.
`define MFAM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("minifloat core assertion failed");
// Next-cycle implication, checked outside of reset.
`define MFAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("minifloat core assertion failed");
`else
`define MFAM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MFAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/mfam_pkg.sv @@
// Package for the minifloat add/multiply core: format constants, codes, types
// and the result packing function. Depends on nothing.
`timescale 1ns / 1ps

package mfam_pkg;

    // Operand format: 5-bit exponent code over a 9-bit fraction, hidden 1.
    localparam int FRAC_W   = 9;
    localparam int EXP_W    = 5;
    localparam int WORD_W   = EXP_W + FRAC_W;
    localparam int MANT_W   = FRAC_W + 1;
    localparam int PROD_W   = 2 * MANT_W;
    localparam int CODE_W   = EXP_W + 2;
    localparam int STATUS_W = 2;
    localparam int EXP_BIAS = 15;

    // Legal range of a packed exponent code.
    localparam logic signed [CODE_W-1:0] CODE_MAX = CODE_W'(30);
    localparam logic signed [CODE_W-1:0] CODE_MIN = CODE_W'(1);

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_MUL = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Unpacked result of either unit: signed exponent code and truncated fraction.
    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic [FRAC_W-1:0]        frac;
    } t_raw;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        t_status           status;
    } t_packed;

    // Range check on the exponent code; an out-of-range result reads as zero.
    function automatic t_packed pack_result(input t_raw raw);
        t_packed p;
        if (raw.code > CODE_MAX) begin
            p.result = '0;
            p.status = ST_OVERFLOW;
        end else if (raw.code < CODE_MIN) begin
            p.result = '0;
            p.status = ST_UNDERFLOW;
        end else begin
            p.result = {raw.code[EXP_W-1:0], raw.frac};
            p.status = ST_OK;
        end
        return p;
    endfunction

endpackage

@@ design/mfam_if.sv @@
// Valid/ready channel interfaces for the minifloat core: request and response.
// Depends on mfam_pkg.
`timescale 1ns / 1ps

interface mfam_req_if;
    import mfam_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface mfam_rsp_if;
    import mfam_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   result;
    logic [STATUS_W-1:0] status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

@@ design/mfam_add.sv @@
// Adder for two minifloats: align by right shift, add, renormalize one place.
// Depends on mfam_pkg.
`timescale 1ns / 1ps

module mfam_add (
    input  logic [mfam_pkg::WORD_W-1:0] i_operand_a,
    input  logic [mfam_pkg::WORD_W-1:0] i_operand_b,
    output mfam_pkg::t_raw              o_raw
);
    import mfam_pkg::*;

    logic [EXP_W-1:0]  ea;
    logic [EXP_W-1:0]  eb;
    logic [EXP_W-1:0]  big_e;
    logic [EXP_W-1:0]  diff;
    logic [MANT_W-1:0] big_m;
    logic [MANT_W-1:0] small_m;
    logic [MANT_W-1:0] shifted;
    logic [MANT_W:0]   sum;

    // Pick the operand with the larger exponent and align the other one.
    always_comb begin
        ea = i_operand_a[WORD_W-1:FRAC_W];
        eb = i_operand_b[WORD_W-1:FRAC_W];
        if (ea >= eb) begin
            big_e   = ea;
            big_m   = {1'b1, i_operand_a[FRAC_W-1:0]};
            small_m = {1'b1, i_operand_b[FRAC_W-1:0]};
            diff    = ea - eb;
        end else begin
            big_e   = eb;
            big_m   = {1'b1, i_operand_b[FRAC_W-1:0]};
            small_m = {1'b1, i_operand_a[FRAC_W-1:0]};
            diff    = eb - ea;
        end
        shifted = small_m >> diff;
        sum     = {1'b0, big_m} + {1'b0, shifted};
    end

    // A carry out moves the binary point one place and bumps the exponent.
    always_comb begin
        o_raw.code = CODE_W'(big_e) + CODE_W'(sum[MANT_W]);
        o_raw.frac = sum[MANT_W] ? sum[FRAC_W:1] : sum[FRAC_W-1:0];
    end

endmodule

@@ design/mfam_mul.sv @@
// Multiplier for two minifloats: exponent add, 10x10 mantissa product,
// renormalize one place. Depends on mfam_pkg.
`timescale 1ns / 1ps

module mfam_mul (
    input  logic [mfam_pkg::WORD_W-1:0] i_operand_a,
    input  logic [mfam_pkg::WORD_W-1:0] i_operand_b,
    output mfam_pkg::t_raw              o_raw
);
    import mfam_pkg::*;

    logic [MANT_W-1:0] ma;
    logic [MANT_W-1:0] mb;
    logic [PROD_W-1:0] prod;
    logic              top_bit;

    // Mantissa product in 2.18 fixed point.
    always_comb begin
        ma      = {1'b1, i_operand_a[FRAC_W-1:0]};
        mb      = {1'b1, i_operand_b[FRAC_W-1:0]};
        prod    = PROD_W'(ma) * PROD_W'(mb);
        top_bit = prod[PROD_W-1];
    end

    // Biased exponent sum, plus one when the product reached 2.0.
    always_comb begin
        o_raw.code = CODE_W'(i_operand_a[WORD_W-1:FRAC_W])
                   + CODE_W'(i_operand_b[WORD_W-1:FRAC_W])
                   - CODE_W'(EXP_BIAS)
                   + CODE_W'(top_bit);
        o_raw.frac = top_bit ? prod[PROD_W-2:PROD_W-1-FRAC_W]
                             : prod[PROD_W-3:PROD_W-2-FRAC_W];
    end

endmodule

@@ design/minifloat_add_multiply_core.sv @@
// Minifloat add/multiply core, top level: request register, add and multiply
// units, result register. Depends on mfam_pkg, mfam_if, mfam_add, mfam_mul.
`timescale 1ns / 1ps
//
// Usage:
//   i_req carries one request: op (0 add, 1 multiply) and two positive
//   14-bit minifloats (5-bit exponent, bias 15, 9-bit fraction, hidden 1).
//   o_rsp returns one response per request, in order: the truncated result
//   and a status (ok, overflow, underflow); result is 0 unless ok.
//   A request moves from the accepting edge into the request register and
//   then into the result register, from which the response can be taken.
//   Throughput is one request per cycle while o_rsp is ready; the arithmetic
//   between the two registers is one 10x10 multiply or one shift and add.
//   When o_rsp stalls, a full result register holds; i_req.ready stays high
//   while the request register is empty or moving; up to two requests are held.
//   Synchronous reset clears both valid flags; no request is pending after it.
//
`include "minifloat_add_multiply_core_macros.svh"

module minifloat_add_multiply_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfam_req_if.sink  i_req,
    mfam_rsp_if.source o_rsp
);
    import mfam_pkg::*;

    logic              r_in_valid;
    logic              r_op;
    logic [WORD_W-1:0] r_operand_a;
    logic [WORD_W-1:0] r_operand_b;
    logic              r_out_valid;
    t_packed           r_out;

    logic              out_ready;
    logic              in_ready;
    t_raw              add_raw;
    t_raw              mul_raw;
    t_raw              sel_raw;
    t_packed           n_out;

    // Each stage moves when the stage after it is empty or draining.
    assign out_ready   = !r_out_valid || o_rsp.ready;
    assign in_ready    = !r_in_valid || out_ready;
    assign i_req.ready = in_ready;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_op        <= i_req.op;
            r_operand_a <= i_req.operand_a;
            r_operand_b <= i_req.operand_b;
        end
    end

    mfam_add u_add (
        .i_operand_a (r_operand_a),
        .i_operand_b (r_operand_b),
        .o_raw       (add_raw)
    );

    mfam_mul u_mul (
        .i_operand_a (r_operand_a),
        .i_operand_b (r_operand_b),
        .o_raw       (mul_raw)
    );

    // Select the unit by opcode and apply the exponent range check.
    always_comb begin
        case (t_op'(r_op))
            OP_MUL:  sel_raw = mul_raw;
            default: sel_raw = add_raw;
        endcase
        n_out = pack_result(sel_raw);
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_out.result;
    assign o_rsp.status = r_out.status;

    // A request that reaches a free result register shows up there next cycle.
    `MFAM_ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, r_in_valid && out_ready, r_out_valid)
    // Requests are refused only with both registers full.
    `MFAM_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !i_req.ready, r_in_valid && r_out_valid)
    // Any status other than ok comes with a zero result.
    `MFAM_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_OK, o_rsp.result == '0)
    // An ok result carries an exponent code inside the legal range.
    `MFAM_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, o_rsp.valid && o_rsp.status == ST_OK, o_rsp.result[WORD_W-1:FRAC_W] != '0 && o_rsp.result[WORD_W-1:FRAC_W] != '1)

endmodule
